// ----- design/shwr_pkg.sv -----
// Package for the single-wire humidity sensor reader.
// Holds shared constants, the sequencer phase type and the frame event record.
// No dependencies.
package shwr_pkg;

    localparam int FRAME_BITS_DEF = 40;
    localparam int NUM_BYTES      = 5;
    localparam int QUEUE_DEPTH    = 4;

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 24;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 24;

    localparam logic [CFG_INDEX_W-1:0] CFG_SENSOR_IS_22  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_WAKE_TICKS    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ZERO_BITS     = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT_TICKS = 2'd3;

    localparam logic        RST_SENSOR_IS_22  = 1'b1;
    localparam logic [23:0] RST_WAKE_TICKS    = 24'd1000;
    localparam logic [5:0]  RST_ZERO_BITS     = 6'd6;
    localparam logic [15:0] RST_TIMEOUT_TICKS = 16'd200;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_CHECKSUM  = 3'd1;
    localparam logic [2:0] ST_NO_RESP   = 3'd2;
    localparam logic [2:0] ST_ACKL_TMO  = 3'd3;
    localparam logic [2:0] ST_ACKH_TMO  = 3'd4;
    localparam logic [2:0] ST_BIT_TMO   = 3'd5;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_WAKE,
        PH_RESP,
        PH_ACKL,
        PH_ACKH,
        PH_BITS
    } t_phase;

    // One record per accepted sample, passed from the sequencer to the decoder.
    typedef struct packed {
        logic                     drive_low;
        logic                     done;
        logic [2:0]               code;
        logic [NUM_BYTES*8-1:0]   bytes;
    } t_evt;

endpackage

// ----- design/shwr_front.sv -----
// Line sequencer of the humidity sensor reader: wake pulse, handshake and bit timing.
// Produces one event record per accepted sample. Depends on shwr_pkg.
module shwr_front #(
    parameter int FRAME_BITS = shwr_pkg::FRAME_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  logic               i_start,
    input  logic               i_level,
    input  logic [23:0]        i_wake_ticks,
    input  logic [5:0]         i_zero_bits,
    input  logic [15:0]        i_timeout_ticks,
    output shwr_pkg::t_evt     o_evt
);

    localparam int BL_W  = $clog2(FRAME_BITS + 1);
    localparam int CMP_W = (BL_W > 6) ? BL_W : 6;
    localparam int NB    = shwr_pkg::NUM_BYTES;
    localparam logic [BL_W-1:0] FRAME_CNT = BL_W'(FRAME_BITS);

    shwr_pkg::t_phase r_phase, n_phase;
    logic [23:0]      r_tick, n_tick;
    logic [BL_W-1:0]  r_bits_left, n_bits_left;
    logic [7:0]       r_shift, n_shift;
    logic [2:0]       r_bib, n_bib;
    logic [7:0]       r_bytes [NB];
    logic [7:0]       n_bytes [NB];
    logic [15:0]      r_zp, n_zp;
    logic             r_prev, n_prev;

    logic [23:0]      w_t1;
    logic [BL_W-1:0]  w_idx;
    logic [BL_W-4:0]  w_byte_no;
    logic [17:0]      w_thr;
    logic             w_bit;
    logic [7:0]       w_new_shift;
    logic             w_finish;
    logic [2:0]       w_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= shwr_pkg::PH_IDLE;
            r_tick      <= '0;
            r_bits_left <= '0;
            r_shift     <= '0;
            r_bib       <= '0;
            r_zp        <= '0;
            r_prev      <= 1'b0;
            for (int k = 0; k < NB; k++) begin
                r_bytes[k] <= '0;
            end
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_tick      <= n_tick;
            r_bits_left <= n_bits_left;
            r_shift     <= n_shift;
            r_bib       <= n_bib;
            r_zp        <= n_zp;
            r_prev      <= n_prev;
            for (int k = 0; k < NB; k++) begin
                r_bytes[k] <= n_bytes[k];
            end
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_tick      = r_tick;
        n_bits_left = r_bits_left;
        n_shift     = r_shift;
        n_bib       = r_bib;
        n_zp        = r_zp;
        n_prev      = i_level;
        for (int k = 0; k < NB; k++) begin
            n_bytes[k] = r_bytes[k];
        end
        w_t1        = r_tick + 24'd1;
        w_idx       = FRAME_CNT - r_bits_left;
        w_byte_no   = w_idx[BL_W-1:3];
        w_thr       = {2'b00, r_zp} + {4'b0000, r_zp[15:2]};
        w_bit       = 1'b0;
        w_new_shift = r_shift;
        w_finish    = 1'b0;
        w_code      = shwr_pkg::ST_OK;
        o_evt.drive_low = 1'b0;

        case (r_phase)
            shwr_pkg::PH_IDLE: begin
                if (i_start) begin
                    for (int k = 0; k < NB; k++) begin
                        n_bytes[k] = '0;
                    end
                    n_zp    = '0;
                    n_tick  = 24'd1;
                    n_phase = shwr_pkg::PH_WAKE;
                    o_evt.drive_low = 1'b1;
                end
            end
            shwr_pkg::PH_WAKE: begin
                if (r_tick < i_wake_ticks) begin
                    n_tick = w_t1;
                    o_evt.drive_low = 1'b1;
                end else begin
                    n_tick  = '0;
                    n_phase = shwr_pkg::PH_RESP;
                end
            end
            shwr_pkg::PH_RESP: begin
                if (!i_level) begin
                    n_tick  = '0;
                    n_phase = shwr_pkg::PH_ACKL;
                end else begin
                    n_tick = w_t1;
                    if (w_t1 >= 24'({i_timeout_ticks, 1'b0})) begin
                        w_finish = 1'b1;
                        w_code   = shwr_pkg::ST_NO_RESP;
                    end
                end
            end
            shwr_pkg::PH_ACKL: begin
                if (i_level) begin
                    n_tick  = '0;
                    n_phase = shwr_pkg::PH_ACKH;
                end else begin
                    n_tick = w_t1;
                    if (w_t1 >= 24'(i_timeout_ticks)) begin
                        w_finish = 1'b1;
                        w_code   = shwr_pkg::ST_ACKL_TMO;
                    end
                end
            end
            shwr_pkg::PH_ACKH: begin
                if (!i_level) begin
                    n_tick      = '0;
                    n_phase     = shwr_pkg::PH_BITS;
                    n_bits_left = FRAME_CNT;
                    n_shift     = '0;
                    n_bib       = '0;
                end else begin
                    n_tick = w_t1;
                    if (w_t1 >= 24'(i_timeout_ticks)) begin
                        w_finish = 1'b1;
                        w_code   = shwr_pkg::ST_ACKH_TMO;
                    end
                end
            end
            shwr_pkg::PH_BITS: begin
                n_tick = w_t1;
                if (!i_level && r_prev) begin
                    if (CMP_W'(w_idx) < CMP_W'(i_zero_bits)) begin
                        if (w_t1 > 24'(r_zp)) begin
                            n_zp = (w_t1 > 24'd65535) ? 16'hFFFF : w_t1[15:0];
                        end
                    end else if (w_t1 >= 24'(w_thr)) begin
                        w_bit = 1'b1;
                    end
                    w_new_shift = {r_shift[6:0], w_bit};
                    n_shift     = w_new_shift;
                    n_bib       = r_bib + 3'd1;
                    if (r_bib == 3'd7) begin
                        for (int k = 0; k < NB; k++) begin
                            if (8'(w_byte_no) == 8'(k)) begin
                                n_bytes[k] = w_new_shift;
                            end
                        end
                        n_shift = '0;
                    end
                    n_tick      = '0;
                    n_bits_left = r_bits_left - BL_W'(1);
                    if (r_bits_left == BL_W'(1)) begin
                        w_finish = 1'b1;
                        w_code   = shwr_pkg::ST_OK;
                    end
                end else if (w_t1 >= 24'(i_timeout_ticks)) begin
                    w_finish = 1'b1;
                    w_code   = shwr_pkg::ST_BIT_TMO;
                end
            end
            default: begin
                n_phase = shwr_pkg::PH_IDLE;
            end
        endcase

        if (w_finish) begin
            n_phase = shwr_pkg::PH_IDLE;
            n_tick  = '0;
        end

        o_evt.done = w_finish;
        o_evt.code = w_code;
        for (int k = 0; k < NB; k++) begin
            o_evt.bytes[k*8 +: 8] = n_bytes[k];
        end
    end

endmodule

// ----- design/shwr_fifo.sv -----
// Short register queue between the sequencer and the decoder of the sensor reader.
// Generic in width and depth; no package dependencies.
module shwr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             w_push, w_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == LAST) ? '0 : r_wr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rd <= (r_rd == LAST) ? '0 : r_rd + PTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

endmodule

// ----- design/shwr_back.sv -----
// Result decoder of the sensor reader: masking, checksum, divide by ten and sign.
// Two register stages feed the output stream. Depends on shwr_pkg.
module shwr_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_sensor_is_22,
    input  logic                            i_valid,
    input  shwr_pkg::t_evt                  i_evt,
    output logic                            o_pop,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [shwr_pkg::M_TDATA_W-1:0]  o_m_tdata
);

    logic [7:0] w_b0, w_b1, w_b2, w_b3, w_b4;
    logic [7:0] w_b0m, w_b2m, w_sum;
    logic [9:0] w_hum_num, w_temp_num;
    logic       w_bad;

    logic        r_s1_valid;
    logic        r_s1_drive, r_s1_done, r_s1_is22, r_s1_neg;
    logic [2:0]  r_s1_code;
    logic [6:0]  r_s1_hum_raw, r_s1_temp_raw;
    logic [17:0] r_s1_hum_prod, r_s1_temp_prod;

    logic        r_out_valid;
    logic        r_out_drive, r_out_done;
    logic [2:0]  r_out_status;
    logic [6:0]  r_out_hum;
    logic [7:0]  r_out_temp;

    logic        w_out_ready, w_s1_ready;
    logic [6:0]  w_hum;
    logic [7:0]  w_tq, w_temp;

    assign w_out_ready = !r_out_valid || i_m_tready;
    assign w_s1_ready  = !r_s1_valid || w_out_ready;
    assign o_pop       = i_valid && w_s1_ready;

    always_comb begin
        w_b0 = i_evt.bytes[7:0];
        w_b1 = i_evt.bytes[15:8];
        w_b2 = i_evt.bytes[23:16];
        w_b3 = i_evt.bytes[31:24];
        w_b4 = i_evt.bytes[39:32];
        if (i_sensor_is_22) begin
            w_b0m = w_b0 & 8'h03;
            w_b2m = w_b2 & 8'h83;
            w_sum = w_b0m + w_b1 + w_b2m + w_b3;
        end else begin
            w_b0m = w_b0 & 8'h7F;
            w_b2m = w_b2 & 8'h7F;
            w_sum = w_b0m + w_b2m;
        end
        w_hum_num  = {w_b0m[1:0], w_b1};
        w_temp_num = {w_b2m[1:0], w_b3};
        w_bad      = (w_b4 != w_sum);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s1_ready) begin
            r_s1_valid <= i_valid;
        end
    end

    // Divide by ten as x * 205 >> 11, exact for ten-bit x.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_drive     <= i_evt.drive_low;
            r_s1_done      <= i_evt.done;
            r_s1_code      <= w_bad ? shwr_pkg::ST_CHECKSUM : i_evt.code;
            r_s1_is22      <= i_sensor_is_22;
            r_s1_neg       <= w_b2m[7];
            r_s1_hum_raw   <= w_b0m[6:0];
            r_s1_temp_raw  <= w_b2m[6:0];
            r_s1_hum_prod  <= w_hum_num * 18'd205;
            r_s1_temp_prod <= w_temp_num * 18'd205;
        end
    end

    always_comb begin
        w_tq = {1'b0, r_s1_temp_prod[17:11]};
        if (r_s1_is22) begin
            w_hum  = r_s1_hum_prod[17:11];
            w_temp = r_s1_neg ? 8'(8'd0 - w_tq) : w_tq;
        end else begin
            w_hum  = r_s1_hum_raw;
            w_temp = {1'b0, r_s1_temp_raw};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_ready) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid && w_out_ready) begin
            r_out_drive  <= r_s1_drive;
            r_out_done   <= r_s1_done;
            r_out_status <= r_s1_done ? r_s1_code : shwr_pkg::ST_OK;
            r_out_hum    <= r_s1_done ? w_hum : 7'd0;
            r_out_temp   <= r_s1_done ? w_temp : 8'd0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'b0000, r_out_temp, r_out_hum, r_out_status, r_out_done,
                         r_out_drive};

endmodule

// ----- design/single_wire_humidity_sensor_reader_top.sv -----
// Top level of the single-wire humidity sensor reader.
// Holds the configuration registers and joins shwr_front, shwr_fifo and shwr_back.
//
//   channel   direction  accepted when                    payload
//   s_axis    in         s_axis_tvalid & s_axis_tready    line sample and start request
//   m_axis    out        m_axis_tvalid & m_axis_tready    drive, done, status, readings
//   cfg       in         i_cfg_valid & o_cfg_ready        register index and data
//
// One sample is accepted every clock while the four-entry queue has room.
// Each sample yields one result item, in order, registered in the queue, then in the decoder's
// first stage and then in its output register.
// The sequencer steps only on accepted samples, so input stalls freeze it.
// Output stalls fill the queue and then drop s_axis_tready.
// Reset is synchronous and clears all control state; no clearing pass is needed.
module single_wire_humidity_sensor_reader_top #(
    parameter int FRAME_BITS = shwr_pkg::FRAME_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // bit 0 start_req, bit 1 line_level
    input  logic [shwr_pkg::S_TDATA_W-1:0]      s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // bit 0 line_drive_low, 1 done_res, 4:2 status, 11:5 humidity, 19:12 temperature
    output logic [shwr_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [shwr_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [shwr_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int EVT_W = $bits(shwr_pkg::t_evt);

    logic        r_sensor_is_22;
    logic [23:0] r_wake_ticks;
    logic [5:0]  r_zero_bits;
    logic [15:0] r_timeout_ticks;

    logic            w_accept;
    logic            w_fifo_full, w_fifo_valid, w_pop;
    shwr_pkg::t_evt  w_evt_in, w_evt_out;
    logic [EVT_W-1:0] w_fifo_q;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !w_fifo_full;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_evt_out     = shwr_pkg::t_evt'(w_fifo_q);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sensor_is_22  <= shwr_pkg::RST_SENSOR_IS_22;
            r_wake_ticks    <= shwr_pkg::RST_WAKE_TICKS;
            r_zero_bits     <= shwr_pkg::RST_ZERO_BITS;
            r_timeout_ticks <= shwr_pkg::RST_TIMEOUT_TICKS;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                shwr_pkg::CFG_SENSOR_IS_22:  r_sensor_is_22  <= i_cfg_data[0];
                shwr_pkg::CFG_WAKE_TICKS:    r_wake_ticks    <= i_cfg_data[23:0];
                shwr_pkg::CFG_ZERO_BITS:     r_zero_bits     <= i_cfg_data[5:0];
                shwr_pkg::CFG_TIMEOUT_TICKS: r_timeout_ticks <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    shwr_front #(
        .FRAME_BITS (FRAME_BITS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (w_accept),
        .i_start         (s_axis_tdata[0]),
        .i_level         (s_axis_tdata[1]),
        .i_wake_ticks    (r_wake_ticks),
        .i_zero_bits     (r_zero_bits),
        .i_timeout_ticks (r_timeout_ticks),
        .o_evt           (w_evt_in)
    );

    shwr_fifo #(
        .WIDTH (EVT_W),
        .DEPTH (shwr_pkg::QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_data  (w_evt_in),
        .o_full  (w_fifo_full),
        .o_valid (w_fifo_valid),
        .i_pop   (w_pop),
        .o_data  (w_fifo_q)
    );

    shwr_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_sensor_is_22 (r_sensor_is_22),
        .i_valid        (w_fifo_valid),
        .i_evt          (w_evt_out),
        .o_pop          (w_pop),
        .o_m_tvalid     (m_axis_tvalid),
        .i_m_tready     (m_axis_tready),
        .o_m_tdata      (m_axis_tdata)
    );

`ifndef SYNTHESIS
    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> !w_fifo_full)
        else $error("sample accepted while the queue is full");

    a_idle_result_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tdata[1]) |-> (m_axis_tdata[19:2] == 18'd0))
        else $error("result without done carries nonzero readings");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[4:2] != 3'd6 && m_axis_tdata[4:2] != 3'd7))
        else $error("status code out of range");

    a_pop_needs_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_fifo_valid)
        else $error("decoder popped an empty queue");
`endif

endmodule
